>>> rtl/core/cxy_pkg.sv
// Shared constants, codes and types of the CoreXY line step generator.
`timescale 1ns / 1ps
`default_nettype none

package cxy_pkg;

    // Default position width in whole steps.
    localparam int POS_BITS_DEF = 24;

    // Fixed widths of the stream payloads.
    localparam int TGT_BITS      = 24;
    localparam int IN_DATA_BITS  = 2 * TGT_BITS;
    localparam int OUT_DATA_BITS = 8;

    // Item kinds carried on the input tuser bit.
    localparam logic MODE_TARGET = 1'b0;
    localparam logic MODE_TICK   = 1'b1;

    // Bit positions of the result fields in the output tdata.
    localparam int OB_STEP_A   = 0;
    localparam int OB_DIR_A    = 1;
    localparam int OB_STEP_B   = 2;
    localparam int OB_DIR_B    = 3;
    localparam int OB_BUSY     = 4;
    localparam int OB_DONE     = 5;
    localparam int OB_REJECTED = 6;

    // Outcome of one Bresenham tick.
    typedef struct packed {
        logic minor_step;
        logic last;
    } t_tick_stat;

    // Result flags of one item, apart from the directions.
    typedef struct packed {
        logic step_a;
        logic step_b;
        logic busy;
        logic done;
        logic rejected;
    } t_flags;

endpackage

`default_nettype wire

>>> rtl/core/cxy_target_plan.sv
// Move planning for a new target: motor deltas, directions and major/minor counts.
`timescale 1ns / 1ps
`default_nettype none

module cxy_target_plan #(
    parameter int POS_BITS = cxy_pkg::POS_BITS_DEF
) (
    input  wire logic [cxy_pkg::TGT_BITS-1:0] i_tx,
    input  wire logic [cxy_pkg::TGT_BITS-1:0] i_ty,
    input  wire logic signed [POS_BITS-1:0]   i_x_pos,
    input  wire logic signed [POS_BITS-1:0]   i_y_pos,
    output logic signed [POS_BITS-1:0]        o_new_x,
    output logic signed [POS_BITS-1:0]        o_new_y,
    output logic [POS_BITS:0]                 o_major,
    output logic [POS_BITS:0]                 o_minor,
    output logic                              o_a_is_major,
    output logic [1:0]                        o_dir_bits
);

    localparam int NB = (POS_BITS < cxy_pkg::TGT_BITS) ? POS_BITS : cxy_pkg::TGT_BITS;

    logic signed [POS_BITS:0]   dx;
    logic signed [POS_BITS:0]   dy;
    logic signed [POS_BITS+1:0] da;
    logic signed [POS_BITS+1:0] db;
    logic [POS_BITS:0]          ma;
    logic [POS_BITS:0]          mb;

    // Low bits of each target field, taken as a two's complement position and
    // sign-extended when the position is wider than the field.
    assign o_new_x = POS_BITS'(signed'(i_tx[NB-1:0]));
    assign o_new_y = POS_BITS'(signed'(i_ty[NB-1:0]));

    assign dx = {o_new_x[POS_BITS-1], o_new_x} - {i_x_pos[POS_BITS-1], i_x_pos};
    assign dy = {o_new_y[POS_BITS-1], o_new_y} - {i_y_pos[POS_BITS-1], i_y_pos};
    assign da = {dx[POS_BITS], dx} + {dy[POS_BITS], dy};
    assign db = {dx[POS_BITS], dx} - {dy[POS_BITS], dy};

    assign ma = da[POS_BITS+1] ? (POS_BITS+1)'(-da) : da[POS_BITS:0];
    assign mb = db[POS_BITS+1] ? (POS_BITS+1)'(-db) : db[POS_BITS:0];

    // A delta of zero counts as the negative direction.
    assign o_dir_bits[0] = da[POS_BITS+1] || (da == '0);
    assign o_dir_bits[1] = db[POS_BITS+1] || (db == '0);

    assign o_a_is_major = (ma >= mb);
    assign o_major      = o_a_is_major ? ma : mb;
    assign o_minor      = o_a_is_major ? mb : ma;

endmodule

`default_nettype wire

>>> rtl/core/cxy_tick_step.sv
// One Bresenham tick: accumulator update, minor step decision and countdown.
`timescale 1ns / 1ps
`default_nettype none

module cxy_tick_step #(
    parameter int POS_BITS = cxy_pkg::POS_BITS_DEF
) (
    input  wire logic [POS_BITS+1:0] i_err,
    input  wire logic [POS_BITS:0]   i_major,
    input  wire logic [POS_BITS:0]   i_minor,
    input  wire logic [POS_BITS:0]   i_remaining,
    output logic [POS_BITS+1:0]      o_err,
    output logic [POS_BITS:0]        o_remaining,
    output cxy_pkg::t_tick_stat      o_stat
);

    logic [POS_BITS+1:0] sum;
    logic [POS_BITS+1:0] major_ext;

    assign major_ext = {1'b0, i_major};
    assign sum       = i_err + {1'b0, i_minor};

    assign o_stat.minor_step = (sum >= major_ext);
    assign o_err             = o_stat.minor_step ? (sum - major_ext) : sum;
    assign o_remaining       = i_remaining - (POS_BITS+1)'(1);
    assign o_stat.last       = (i_remaining == (POS_BITS+1)'(1));

endmodule

`default_nettype wire

>>> rtl/core/corexy_line_step_generator_unit.sv
// Top level of the CoreXY line step generator: stream ports, move state and result register.
//
//  Channel  | Direction | Ports               | Word contents (lowest bit first)
//  ---------+-----------+---------------------+-----------------------------------------------
//  s_axis   | in        | tvalid/tready/tdata | tdata: target_x[23:0], target_y[47:24]
//           |           | tuser               | tuser: mode (0 = new target, 1 = step tick)
//  m_axis   | out       | tvalid/tready/tdata | step_a, dir_a, step_b, dir_b, busy_res,
//           |           |                     | done_res, rejected, one zero pad bit
//
// Every input word yields exactly one output word: the word is first held in the
// input register, and when the result register advances, the planning or tick
// logic writes the move state and the result register together.
// A new word is accepted every cycle while the output is not stalled; the Bresenham
// accumulator and counters are updated once for each word.
// Reset (i_rst_n low, synchronous) clears both pipeline stages and returns the move
// state to position zero, idle, motor A major. When the output is stalled, the input
// register still accepts one more word and then holds until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module corexy_line_step_generator_unit #(
    parameter int POS_BITS = cxy_pkg::POS_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // target_x [23:0], target_y [47:24]
    input  wire logic [cxy_pkg::IN_DATA_BITS-1:0]   i_s_axis_tdata,
    // mode [0]
    input  wire logic [0:0]                         i_s_axis_tuser,
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    // step_a [0], dir_a [1], step_b [2], dir_b [3], busy_res [4], done_res [5],
    // rejected [6], zero [7]
    output logic [cxy_pkg::OUT_DATA_BITS-1:0]       o_m_axis_tdata
);

    // Input register.
    logic                             r_in_valid;
    logic                             r_in_mode;
    logic [cxy_pkg::TGT_BITS-1:0]     r_in_tx;
    logic [cxy_pkg::TGT_BITS-1:0]     r_in_ty;

    // Move state.
    logic signed [POS_BITS-1:0]       r_x_pos,   n_x_pos;
    logic signed [POS_BITS-1:0]       r_y_pos,   n_y_pos;
    logic [POS_BITS:0]                r_major_rem, n_major_rem;
    logic [POS_BITS:0]                r_major,   n_major;
    logic [POS_BITS:0]                r_minor,   n_minor;
    logic [POS_BITS+1:0]              r_err,     n_err;
    logic                             r_a_is_major, n_a_is_major;
    logic [1:0]                       r_dir_bits, n_dir_bits;
    logic                             r_moving,  n_moving;

    // Result register.
    logic                             r_out_valid;
    logic [cxy_pkg::OUT_DATA_BITS-1:0] r_out_data, n_out_data;

    logic                             w_adv;
    logic                             w_fire;
    cxy_pkg::t_flags                  w_flags;

    // Planner and tick unit outputs.
    logic signed [POS_BITS-1:0]       w_plan_x;
    logic signed [POS_BITS-1:0]       w_plan_y;
    logic [POS_BITS:0]                w_plan_major;
    logic [POS_BITS:0]                w_plan_minor;
    logic                             w_plan_a_major;
    logic [1:0]                       w_plan_dir;
    logic [POS_BITS+1:0]              w_tick_err;
    logic [POS_BITS:0]                w_tick_rem;
    cxy_pkg::t_tick_stat              w_tick_stat;

    // The result register moves whenever it is empty or being drained.
    assign w_adv           = !r_out_valid || i_m_axis_tready;
    assign w_fire          = w_adv && r_in_valid;
    assign o_s_axis_tready = !r_in_valid || w_adv;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    cxy_target_plan #(
        .POS_BITS(POS_BITS)
    ) u_plan (
        .i_tx         (r_in_tx),
        .i_ty         (r_in_ty),
        .i_x_pos      (r_x_pos),
        .i_y_pos      (r_y_pos),
        .o_new_x      (w_plan_x),
        .o_new_y      (w_plan_y),
        .o_major      (w_plan_major),
        .o_minor      (w_plan_minor),
        .o_a_is_major (w_plan_a_major),
        .o_dir_bits   (w_plan_dir)
    );

    cxy_tick_step #(
        .POS_BITS(POS_BITS)
    ) u_tick (
        .i_err       (r_err),
        .i_major     (r_major),
        .i_minor     (r_minor),
        .i_remaining (r_major_rem),
        .o_err       (w_tick_err),
        .o_remaining (w_tick_rem),
        .o_stat      (w_tick_stat)
    );

    // Next move state and result flags for the word in the input register.
    always_comb begin
        n_x_pos      = r_x_pos;
        n_y_pos      = r_y_pos;
        n_major_rem  = r_major_rem;
        n_major      = r_major;
        n_minor      = r_minor;
        n_err        = r_err;
        n_a_is_major = r_a_is_major;
        n_dir_bits   = r_dir_bits;
        n_moving     = r_moving;
        w_flags      = '0;

        case (r_in_mode)
            cxy_pkg::MODE_TARGET: begin
                if (r_moving) begin
                    // A target during a move is dropped; the move goes on.
                    w_flags.busy     = 1'b1;
                    w_flags.rejected = 1'b1;
                end else begin
                    n_x_pos      = w_plan_x;
                    n_y_pos      = w_plan_y;
                    n_a_is_major = w_plan_a_major;
                    n_major      = w_plan_major;
                    n_minor      = w_plan_minor;
                    n_major_rem  = w_plan_major;
                    n_err        = '0;
                    n_dir_bits   = w_plan_dir;
                    n_moving     = (w_plan_major != '0);
                    w_flags.busy = n_moving;
                    w_flags.done = !n_moving;
                end
            end
            cxy_pkg::MODE_TICK: begin
                if (!r_moving || (r_major_rem == '0)) begin
                    n_moving = 1'b0;
                end else begin
                    // The major motor always steps; the accumulator decides the minor one.
                    n_err          = w_tick_err;
                    n_major_rem    = w_tick_rem;
                    n_moving       = !w_tick_stat.last;
                    w_flags.busy   = !w_tick_stat.last;
                    w_flags.done   = w_tick_stat.last;
                    w_flags.step_a = r_a_is_major ? 1'b1 : w_tick_stat.minor_step;
                    w_flags.step_b = r_a_is_major ? w_tick_stat.minor_step : 1'b1;
                end
            end
            default: begin
                n_moving = r_moving;
            end
        endcase

        n_out_data                       = '0;
        n_out_data[cxy_pkg::OB_STEP_A]   = w_flags.step_a;
        n_out_data[cxy_pkg::OB_DIR_A]    = n_dir_bits[0];
        n_out_data[cxy_pkg::OB_STEP_B]   = w_flags.step_b;
        n_out_data[cxy_pkg::OB_DIR_B]    = n_dir_bits[1];
        n_out_data[cxy_pkg::OB_BUSY]     = w_flags.busy;
        n_out_data[cxy_pkg::OB_DONE]     = w_flags.done;
        n_out_data[cxy_pkg::OB_REJECTED] = w_flags.rejected;
    end

    // Input register: loads on an accepted word, empties when its result is written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_mode <= i_s_axis_tuser[0];
            r_in_tx   <= i_s_axis_tdata[cxy_pkg::TGT_BITS-1:0];
            r_in_ty   <= i_s_axis_tdata[cxy_pkg::IN_DATA_BITS-1:cxy_pkg::TGT_BITS];
        end
    end

    // Move state is architectural, so reset returns all of it to its start values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_pos      <= '0;
            r_y_pos      <= '0;
            r_major_rem  <= '0;
            r_major      <= '0;
            r_minor      <= '0;
            r_err        <= '0;
            r_a_is_major <= 1'b1;
            r_dir_bits   <= '0;
            r_moving     <= 1'b0;
        end else if (w_fire) begin
            r_x_pos      <= n_x_pos;
            r_y_pos      <= n_y_pos;
            r_major_rem  <= n_major_rem;
            r_major      <= n_major;
            r_minor      <= n_minor;
            r_err        <= n_err;
            r_a_is_major <= n_a_is_major;
            r_dir_bits   <= n_dir_bits;
            r_moving     <= n_moving;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_data <= n_out_data;
        end
    end

    // A move in progress always has ticks left.
    a_moving_has_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_moving |-> (r_major_rem != '0))
        else $error("move active with no steps remaining");

    // The Bresenham error stays below the major count during a move.
    a_err_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_moving |-> (r_err < {1'b0, r_major}))
        else $error("Bresenham accumulator out of range");

    // The countdown never exceeds the move length.
    a_rem_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_major_rem <= r_major)
        else $error("remaining steps exceed major count");

    // A target taken while moving leaves the position untouched.
    a_reject_keeps_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (r_in_mode == cxy_pkg::MODE_TARGET) && r_moving)
        |=> ($stable(r_x_pos) && $stable(r_y_pos) && r_moving))
        else $error("rejected target changed the move state");

endmodule

`default_nettype wire

>>> dv/corexy_line_step_generator_unit_tb.sv
// Self-checking testbench of the CoreXY line step generator with a word-level motion predictor.
`timescale 1ns / 1ps

module corexy_line_step_generator_unit_tb;

    localparam int POS_W       = cxy_pkg::POS_BITS_DEF;
    localparam int CNT_W       = POS_W + 1;
    localparam int ERR_W       = POS_W + 2;
    localparam int CYCLE_LIMIT = 500_000;
    localparam int HOLD_CYCLES = 80;
    localparam int DRAIN_WAIT  = 20;

    // One result word, packed in the same order as the output tdata.
    typedef struct packed {
        logic rejected;
        logic done;
        logic busy;
        logic dir_b;
        logic step_b;
        logic dir_a;
        logic step_a;
    } t_motor_word;

    logic                              i_clk   = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic [cxy_pkg::IN_DATA_BITS-1:0]  s_tdata  = '0;
    logic [0:0]                        s_tuser  = '0;
    logic                              m_tready = 1'b0;
    wire                               s_tready;
    wire                               m_tvalid;
    wire  [cxy_pkg::OUT_DATA_BITS-1:0] m_tdata;

    corexy_line_step_generator_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    always #4 i_clk = ~i_clk;

    // Predicted gantry state, updated as each input word is accepted.
    logic signed [POS_W-1:0] pos_x      = '0;
    logic signed [POS_W-1:0] pos_y      = '0;
    logic [CNT_W-1:0]        ticks_left = '0;
    logic [CNT_W-1:0]        major_cnt  = '0;
    logic [CNT_W-1:0]        minor_cnt  = '0;
    logic [ERR_W-1:0]        bres_err   = '0;
    logic                    a_major    = 1'b1;
    logic [1:0]              dir_ab     = '0;
    logic                    in_motion  = 1'b0;

    t_motor_word motion_q[$];
    int          fail_count = 0;
    int          words_sent = 0;
    int          cycle_cnt  = 0;
    bit          no_idle    = 0;
    bit          hold_req   = 0;

    // Predicts the result word of one input word and advances the predicted state.
    function automatic t_motor_word predict_motion(logic mode, logic signed [POS_W-1:0] tx,
                                                   logic signed [POS_W-1:0] ty);
        t_motor_word w;
        longint      dx, dy, da, db;
        logic [CNT_W-1:0] cnt_a, cnt_b;
        logic        minor_hit;
        w = '0;
        if (mode == cxy_pkg::MODE_TARGET) begin
            if (in_motion) begin
                // A target during a move is dropped and the move carries on.
                w.busy     = 1'b1;
                w.rejected = 1'b1;
            end else begin
                dx = longint'(tx) - longint'(pos_x);
                dy = longint'(ty) - longint'(pos_y);
                da = dx + dy;
                db = dx - dy;
                // A zero motor delta counts as the negative direction.
                dir_ab[0] = !(da > 0);
                dir_ab[1] = !(db > 0);
                cnt_a = CNT_W'((da < 0) ? -da : da);
                cnt_b = CNT_W'((db < 0) ? -db : db);
                pos_x      = tx;
                pos_y      = ty;
                a_major    = (cnt_a >= cnt_b);
                major_cnt  = a_major ? cnt_a : cnt_b;
                minor_cnt  = a_major ? cnt_b : cnt_a;
                ticks_left = major_cnt;
                bres_err   = '0;
                in_motion  = (major_cnt != 0);
                w.busy     = in_motion;
                w.done     = !in_motion;
            end
        end else if (!in_motion || ticks_left == 0) begin
            in_motion = 1'b0;
        end else begin
            minor_hit = 1'b0;
            bres_err  = bres_err + ERR_W'(minor_cnt);
            if (bres_err >= ERR_W'(major_cnt)) begin
                minor_hit = 1'b1;
                bres_err  = bres_err - ERR_W'(major_cnt);
            end
            ticks_left = ticks_left - 1'b1;
            in_motion  = (ticks_left != 0);
            w.step_a   = a_major ? 1'b1 : minor_hit;
            w.step_b   = a_major ? minor_hit : 1'b1;
            w.busy     = in_motion;
            w.done     = !in_motion;
        end
        w.dir_a = dir_ab[0];
        w.dir_b = dir_ab[1];
        return w;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Offers one word after a random gap and records its prediction once accepted.
    // tvalid stays high on return so that a following word can go out back to back.
    task automatic send_word(input logic mode, input logic [POS_W-1:0] tx,
                             input logic [POS_W-1:0] ty);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {ty, tx};
        do @(posedge i_clk); while (!s_tready);
        motion_q.push_back(predict_motion(mode, tx, ty));
        words_sent++;
    endtask

    // A tick carries random data, which the block must ignore.
    task automatic send_tick();
        send_word(cxy_pkg::MODE_TICK, POS_W'($urandom), POS_W'($urandom));
    endtask

    // A target anywhere in the field range; only used while a move is running.
    task automatic send_wild_target();
        send_word(cxy_pkg::MODE_TARGET, POS_W'($urandom), POS_W'($urandom));
    endtask

    // A target a few steps away from the current position, so the move stays short.
    task automatic send_near_target();
        int nx, ny;
        nx = int'(pos_x) + $urandom_range(0, 24) - 12;
        ny = int'(pos_y) + $urandom_range(0, 24) - 12;
        send_word(cxy_pkg::MODE_TARGET, POS_W'(nx), POS_W'(ny));
    endtask

    // Ticks until the predicted move is over.
    task automatic finish_move();
        while (in_motion) send_tick();
    endtask

    // Stops offering words and waits until every predicted result has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (motion_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic want, input logic got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %b, actual %b", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Output side: compares every accepted word with the oldest prediction and
    // decides the next tready, including the long hold-off on request.
    int hold_left = 0;
    int rx_gap    = 0;

    always @(posedge i_clk) begin : rx_side
        t_motor_word want, got;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.step_a   = m_tdata[cxy_pkg::OB_STEP_A];
            got.dir_a    = m_tdata[cxy_pkg::OB_DIR_A];
            got.step_b   = m_tdata[cxy_pkg::OB_STEP_B];
            got.dir_b    = m_tdata[cxy_pkg::OB_DIR_B];
            got.busy     = m_tdata[cxy_pkg::OB_BUSY];
            got.done     = m_tdata[cxy_pkg::OB_DONE];
            got.rejected = m_tdata[cxy_pkg::OB_REJECTED];
            if (motion_q.size() == 0) begin
                $display("%0t: unexpected result word, expected none, actual %b", $time, got);
                fail_count++;
            end else begin
                want = motion_q.pop_front();
                check_field("step_a", want.step_a, got.step_a);
                check_field("dir_a", want.dir_a, got.dir_a);
                check_field("step_b", want.step_b, got.step_b);
                check_field("dir_b", want.dir_b, got.dir_b);
                check_field("busy_res", want.busy, got.busy);
                check_field("done_res", want.done, got.done);
                check_field("rejected", want.rejected, got.rejected);
            end
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (hold_req) begin
            hold_req  = 0;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_tready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 3) == 0) begin
            rx_gap = pick_gap();
            m_tready <= (rx_gap == 0);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Ticks right after reset: idle, no steps, reset directions.
    task automatic test_idle_ticks();
        send_tick();
        send_tick();
    endtask

    // A target equal to the current position gives an empty move with both directions set.
    task automatic test_zero_delta();
        send_word(cxy_pkg::MODE_TARGET, '0, '0);
        send_tick();
    endtask

    // Pure X and pure Y moves give equal counts, so both motors step on every tick.
    // Then a move with B as major motor and one with A major in the negative direction.
    task automatic test_shaped_moves();
        send_word(cxy_pkg::MODE_TARGET, POS_W'(3), POS_W'(0));
        finish_move();
        send_tick();
        send_word(cxy_pkg::MODE_TARGET, POS_W'(3), POS_W'(2));
        finish_move();
        send_word(cxy_pkg::MODE_TARGET, POS_W'(5), POS_W'(1));
        finish_move();
        send_word(cxy_pkg::MODE_TARGET, POS_W'(2), POS_W'(0));
        finish_move();
    endtask

    // Targets during a move are rejected, with extreme field values among them.
    task automatic test_busy_reject();
        send_word(cxy_pkg::MODE_TARGET, POS_W'(4), POS_W'(-3));
        send_tick();
        send_word(cxy_pkg::MODE_TARGET, {POS_W{1'b1}}, {POS_W{1'b1}});
        send_word(cxy_pkg::MODE_TARGET, {1'b0, {(POS_W-1){1'b1}}},
                  {1'b1, {(POS_W-1){1'b0}}});
        finish_move();
        drain();
    endtask

    // Mostly complete moves with random content; the rest are stray ticks,
    // targets that arrive mid-move, and spare ticks once a move is done.
    task automatic test_random_moves(input int count);
        int stop_at;
        stop_at = words_sent + count;
        while (words_sent < stop_at) begin
            if ($urandom_range(0, 9) == 0)
                no_idle = ~no_idle;
            if ($urandom_range(0, 4) != 0) begin
                if (!in_motion)
                    send_near_target();
                while (in_motion) begin
                    if ($urandom_range(0, 11) == 0)
                        send_wild_target();
                    else
                        send_tick();
                end
                if ($urandom_range(0, 3) == 0)
                    send_tick();
            end else if (in_motion) begin
                send_wild_target();
            end else begin
                send_tick();
            end
        end
        no_idle = 0;
        drain();
    endtask

    // The receiver stalls for a long stretch while words keep coming, so the
    // block fills and holds off its input; then the sender waits for all results.
    task automatic test_backpressure();
        no_idle  = 1;
        hold_req = 1;
        repeat (30) begin
            if (in_motion)
                send_tick();
            else
                send_near_target();
        end
        no_idle = 0;
        drain();
        finish_move();
        drain();
    endtask

    // A move to the far corner of the field: far too long to finish, so it only
    // runs a few ticks, with rejected targets in between.
    task automatic test_far_corner();
        send_word(cxy_pkg::MODE_TARGET, {1'b0, {(POS_W-1){1'b1}}},
                  {1'b1, {(POS_W-1){1'b0}}});
        repeat (20) begin
            if ($urandom_range(0, 2) == 0)
                send_wild_target();
            else
                send_tick();
        end
        drain();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_ticks();
        test_zero_delta();
        test_shaped_moves();
        test_busy_reject();
        test_random_moves(360);
        test_backpressure();
        test_far_corner();

        drain();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog on the whole run.
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/cxy_pkg.sv
rtl/core/cxy_target_plan.sv
rtl/core/cxy_tick_step.sv
rtl/core/corexy_line_step_generator_unit.sv
dv/corexy_line_step_generator_unit_tb.sv
